[design/bqlp_pkg.sv]
package bqlp_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int PRIME_W    = 32;
    localparam int HALF_W     = PRIME_W / 2;
    localparam int DELAY_W    = 48;
    localparam int FRAC_W     = 24;
    localparam int MUL_A_W    = COEF_W + 1;
    localparam int PROD_W     = MUL_A_W + COEF_W;
    localparam int ACC_W      = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shifts that line partial products up with the accumulator.
    localparam int LO_SHIFT    = 21;
    localparam int HI_SHIFT    = FRAC_W - LO_SHIFT;
    localparam int PRIME_SHIFT = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME  = 3'd6;

    // Input kinds.
    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_PRIME  = 1'b1;

    // Sequencer steps.
    localparam logic [3:0] PRIME_ISSUE = 4'd2;
    localparam logic [3:0] PRIME_LAST  = 4'd3;
    localparam logic [3:0] NODE_STEPS  = 4'd4;
    localparam logic [3:0] FILT_ISSUE  = 4'd10;
    localparam logic [3:0] FILT_LAST   = 4'd10;

    // Operand pairs of the filter pass, two partial products each.
    localparam logic [2:0] PAIR_D1A1 = 3'd0;
    localparam logic [2:0] PAIR_D2A2 = 3'd1;
    localparam logic [2:0] PAIR_D1B1 = 3'd2;
    localparam logic [2:0] PAIR_D2B2 = 3'd3;
    localparam logic [2:0] PAIR_NDB0 = 3'd4;

    localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
    localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(1) <<< (FRAC_W - 1);

    // Sample widened to Q24.24 in accumulator width.
    function automatic logic signed [ACC_W-1:0] to_q24(input logic signed [SAMPLE_W-1:0] s);
        return {{(ACC_W-SAMPLE_W-FRAC_W){s[SAMPLE_W-1]}}, s, {FRAC_W{1'b0}}};
    endfunction

endpackage

[design/bqlp_in_if.sv]
interface bqlp_in_if
    import bqlp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

[design/bqlp_out_if.sv]
interface bqlp_out_if
    import bqlp_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

[design/biquad_lowpass_filter_core.sv]
// Second-order low-pass biquad in direct form II with Q2.21 coefficients
// and Q24.24 delay elements.
// Items arrive on i_smp (kind, sample) with a valid/ready handshake; each
// accepted item yields exactly one filtered sample on o_res. A prime item
// first loads both delay elements with the sample times prime_scale.
// Coefficients, bypass and prime_scale are written through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write them only
// while the block is idle, which the block itself does not enforce.
// All multiplies share one 25x24 signed multiplier with a registered
// product. A filter item takes ten partial products, then drains and
// finishes into the output register; no new item is taken until then.
// A prime item first forms two products of the sample and prime_scale.
// In bypass a filter item needs no products and a prime item only its two.
// i_smp.ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it
// there, and the block then still accepts and works one more item, which
// waits in its last step until the output register frees up.
// Synchronous reset clears the delay elements, sets bypass and zeroes
// all coefficients and prime_scale.
module biquad_lowpass_filter_core
    import bqlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bqlp_in_if.sink               i_smp,
    bqlp_out_if.source            o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_FILT  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Configuration registers.
    logic                       r_bypass;
    logic signed [COEF_W-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [PRIME_W-1:0]         r_prime;

    // Filter state.
    logic signed [DELAY_W-1:0]  r_d1, r_d2;

    // Sequencer.
    t_state                     r_state, n_state;
    logic [3:0]                 r_step, n_step;

    // Datapath.
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_aval;
    logic                       r_aprime;
    logic [3:0]                 r_astep;
    logic signed [ACC_W-1:0]    r_node;
    logic signed [ACC_W-1:0]    r_acc;

    // Output register.
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic                       in_fire;
    logic                       out_free;
    logic                       issue;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [DELAY_W-1:0]  src;
    logic signed [COEF_W-1:0]   coef;
    logic signed [ACC_W-1:0]    prod_x;
    logic signed [ACC_W-1:0]    term;
    logic                       node_ok;
    logic signed [DELAY_W-1:0]  node_val;
    logic                       prime_ok;
    logic signed [DELAY_W-1:0]  prime_val;
    logic signed [ACC_W-1:0]    rnd;
    logic                       y_ok;
    logic signed [SAMPLE_W-1:0] y;
    logic                       finish;

    assign i_smp.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_data;

    assign in_fire  = i_smp.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_res.ready;
    assign finish   = (r_state == S_DONE) && out_free;

    assign issue = ((r_state == S_PRIME) && (r_step < PRIME_ISSUE))
                || ((r_state == S_FILT) && (r_step < FILT_ISSUE));

    // The node falls back to the sample when the feedback sum leaves the
    // 48-bit range.
    assign node_ok  = (&r_node[ACC_W-1:DELAY_W-1]) || !(|r_node[ACC_W-1:DELAY_W-1]);
    assign node_val = node_ok ? r_node[DELAY_W-1:0] : DELAY_W'(to_q24(r_sample));

    // The priming product is Q.16; it moves up by eight bits and saturates.
    assign prime_ok = (&r_acc[ACC_W-1:DELAY_W-1-PRIME_SHIFT])
                   || !(|r_acc[ACC_W-1:DELAY_W-1-PRIME_SHIFT]);
    assign prime_val = prime_ok ? {r_acc[DELAY_W-1-PRIME_SHIFT:0], {PRIME_SHIFT{1'b0}}}
                                : (r_acc[ACC_W-1] ? DELAY_MIN : DELAY_MAX);

    // Round half up to an integer and saturate to the output width.
    assign rnd  = r_acc + ROUND_HALF;
    assign y_ok = (&rnd[ACC_W-1:FRAC_W+SAMPLE_W-1]) || !(|rnd[ACC_W-1:FRAC_W+SAMPLE_W-1]);
    assign y    = y_ok ? rnd[FRAC_W+SAMPLE_W-1:FRAC_W] : (rnd[ACC_W-1] ? OUT_MIN : OUT_MAX);

    // Each 48x24 product is split at bit 24 of the delay operand: even
    // steps take the signed upper half, odd steps the unsigned lower half.
    always_comb begin
        src  = r_d1;
        coef = r_a1;
        case (r_step[3:1])
            PAIR_D1A1: begin
                src  = r_d1;
                coef = r_a1;
            end
            PAIR_D2A2: begin
                src  = r_d2;
                coef = r_a2;
            end
            PAIR_D1B1: begin
                src  = r_d1;
                coef = r_b1;
            end
            PAIR_D2B2: begin
                src  = r_d2;
                coef = r_b2;
            end
            PAIR_NDB0: begin
                src  = node_val;
                coef = r_b0;
            end
            default: begin
                src  = r_d1;
                coef = r_a1;
            end
        endcase
        if (r_state == S_PRIME) begin
            mul_a = MUL_A_W'(r_sample);
            mul_b = r_step[0] ? {{(COEF_W-HALF_W){1'b0}}, r_prime[PRIME_W-1:HALF_W]}
                              : {{(COEF_W-HALF_W){1'b0}}, r_prime[HALF_W-1:0]};
        end else begin
            mul_a = r_step[0] ? {1'b0, src[FRAC_W-1:0]}
                              : {src[DELAY_W-1], src[DELAY_W-1:FRAC_W]};
            mul_b = coef;
        end
    end

    // The upper half scales by 2^3, the lower half floors by 2^21; their
    // sum is floor(d * c / 2^21).
    assign prod_x = ACC_W'(r_prod);
    assign term   = r_astep[0] ? (prod_x >>> LO_SHIFT) : (prod_x <<< HI_SHIFT);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_step = '0;
                    if (i_smp.kind == KIND_PRIME) begin
                        n_state = S_PRIME;
                    end else if (r_bypass) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FILT;
                    end
                end
            end
            S_PRIME: begin
                if (r_step == PRIME_LAST) begin
                    n_step  = '0;
                    n_state = r_bypass ? S_DONE : S_FILT;
                end else begin
                    n_step = 4'(r_step + 4'd1);
                end
            end
            S_FILT: begin
                if (r_step == FILT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_step = 4'(r_step + 4'd1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and delay elements.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_aval      <= 1'b0;
            r_out_valid <= 1'b0;
            r_bypass    <= 1'b1;
            r_b0        <= '0;
            r_b1        <= '0;
            r_b2        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            r_prime     <= '0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_aval  <= issue;

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BYPASS: r_bypass <= i_cfg_data[0];
                    REG_B0:     r_b0     <= i_cfg_data[COEF_W-1:0];
                    REG_B1:     r_b1     <= i_cfg_data[COEF_W-1:0];
                    REG_B2:     r_b2     <= i_cfg_data[COEF_W-1:0];
                    REG_A1:     r_a1     <= i_cfg_data[COEF_W-1:0];
                    REG_A2:     r_a2     <= i_cfg_data[COEF_W-1:0];
                    REG_PRIME:  r_prime  <= i_cfg_data[PRIME_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_PRIME) && (r_step == PRIME_LAST)) begin
                r_d1 <= prime_val;
                r_d2 <= prime_val;
            end else if (finish && !r_bypass) begin
                r_d2 <= r_d1;
                r_d1 <= node_val;
            end
        end
    end

    // Multiplier, accumulators and output data.
    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_astep  <= r_step;
        r_aprime <= (r_state == S_PRIME);

        if (in_fire) begin
            r_sample <= i_smp.sample;
        end

        if (r_aval) begin
            if (r_aprime) begin
                if (!r_astep[0]) begin
                    r_acc <= prod_x;
                end else begin
                    r_acc <= r_acc + (prod_x <<< HALF_W);
                end
            end else if (r_astep < NODE_STEPS) begin
                r_node <= r_node - term;
            end else begin
                r_acc <= r_acc + term;
            end
        end

        if (in_fire) begin
            r_node <= to_q24(i_smp.sample);
            r_acc  <= '0;
        end else if ((r_state == S_PRIME) && (r_step == PRIME_LAST)) begin
            r_node <= to_q24(r_sample);
            r_acc  <= '0;
        end

        if (finish) begin
            r_out_data <= r_bypass ? r_sample : y;
        end
    end

endmodule

[design/bqlp_chk.sv]
module bqlp_chk
    import bqlp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_data
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] r_cnt;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // Items accepted whose result has not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire && !out_fire) begin
            r_cnt <= 2'(r_cnt + 2'd1);
        end else if (out_fire && !in_fire) begin
            r_cnt <= 2'(r_cnt - 2'd1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in_ready)
        else $error("item accepted in the cycle after another item");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two items outstanding");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("result shown with no item outstanding");

endmodule

bind biquad_lowpass_filter_core bqlp_chk u_bqlp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.filtered)
);

[test/bqlp_result_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration port and both item channels, works out the
// filtered sample for every accepted input item and compares it with what
// comes out on the result channel, oldest first.
module bqlp_result_checker
    import bqlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bqlp_in_if                    i_smp,
    bqlp_out_if                   i_res,
    output int                    o_pending,
    output int                    o_fail_count
);

    typedef logic signed [79:0] wide_t;

    localparam int    COEF_FRAC  = 21;
    localparam wide_t DELAY_HI   = 80'sh7FFF_FFFF_FFFF;
    localparam wide_t DELAY_LO   = -DELAY_HI - 1;
    localparam wide_t ROUND_BIAS = 80'sd8388608;
    localparam wide_t FILT_HI    = 80'sd32767;
    localparam wide_t FILT_LO    = -80'sd32768;

    logic                       bypass_q;
    logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
    logic [PRIME_W-1:0]         prime_q;
    logic signed [DELAY_W-1:0]  d1_q, d2_q;
    logic signed [SAMPLE_W-1:0] filtered_q[$];

    // Exact product of a Q24.24 value and a Q2.21 coefficient, floored back to Q.24.
    function automatic wide_t mul_q21(input logic signed [DELAY_W-1:0] d,
                                      input logic signed [COEF_W-1:0] c);
        wide_t prod;
        prod = d * c;
        return prod >>> COEF_FRAC;
    endfunction

    // One item through the biquad; updates the delay line as the block does.
    function automatic logic signed [SAMPLE_W-1:0] run_biquad(
        input logic kind, input logic signed [SAMPLE_W-1:0] smp);
        wide_t s_q, load, node, acc, y;
        s_q = smp;
        s_q = s_q <<< FRAC_W;
        if (kind == KIND_PRIME) begin
            load = smp * $signed({16'b0, prime_q});
            load = load <<< PRIME_SHIFT;
            if (load > DELAY_HI) load = DELAY_HI;
            else if (load < DELAY_LO) load = DELAY_LO;
            d1_q = load[DELAY_W-1:0];
            d2_q = load[DELAY_W-1:0];
        end
        if (bypass_q) return smp;
        node = s_q - mul_q21(d1_q, a1_q) - mul_q21(d2_q, a2_q);
        // A feedback sum outside the delay range is replaced by the sample.
        if (node > DELAY_HI || node < DELAY_LO) node = s_q;
        acc = mul_q21(node[DELAY_W-1:0], b0_q) + mul_q21(d1_q, b1_q) + mul_q21(d2_q, b2_q);
        d2_q = d1_q;
        d1_q = node[DELAY_W-1:0];
        y = (acc + ROUND_BIAS) >>> FRAC_W;
        if (y > FILT_HI) y = FILT_HI;
        else if (y < FILT_LO) y = FILT_LO;
        return y[SAMPLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            bypass_q = 1'b1;
            b0_q = '0;
            b1_q = '0;
            b2_q = '0;
            a1_q = '0;
            a2_q = '0;
            prime_q = '0;
            d1_q = '0;
            d2_q = '0;
            filtered_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: filtered %0d arrived with nothing expected",
                             $time, i_res.filtered);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_res.filtered !== want) begin
                        $display("%0t: filtered expected %0d, got %0d",
                                 $time, want, i_res.filtered);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BYPASS: bypass_q = i_cfg_data[0];
                    REG_B0:     b0_q = i_cfg_data[COEF_W-1:0];
                    REG_B1:     b1_q = i_cfg_data[COEF_W-1:0];
                    REG_B2:     b2_q = i_cfg_data[COEF_W-1:0];
                    REG_A1:     a1_q = i_cfg_data[COEF_W-1:0];
                    REG_A2:     a2_q = i_cfg_data[COEF_W-1:0];
                    REG_PRIME:  prime_q = i_cfg_data[PRIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready)
                filtered_q.push_back(run_biquad(i_smp.kind, i_smp.sample));
        end
        o_pending <= filtered_q.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

// Testbench top for the biquad low-pass core. This module only makes
// stimulus and gives the verdict; prediction and comparison live in the
// result checker instantiated beside the block.
module tb_top;
    import bqlp_pkg::*;

    // Cycles allowed after the last expected result before the block is
    // treated as idle, so that any stray result has room to show up.
    localparam int SETTLE_CYCLES = 30;
    // The watchdog ends the run after this many cycles without any
    // handshake or register write.
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int COEF_MAX = 8388607;
    localparam int COEF_MIN = -8388608;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int pending;
    int fail_count;

    // Idling modes for the two sides: 0 means no gaps at all, 1 means
    // random gaps. They change from phase to phase.
    int send_mode;
    int take_mode;

    // Last sample handed out, so that slowly moving signals can be built.
    logic signed [SAMPLE_W-1:0] walk;

    bqlp_in_if  smp_bus ();
    bqlp_out_if res_bus ();

    biquad_lowpass_filter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_bus),
        .o_res      (res_bus)
    );

    bqlp_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_smp        (smp_bus),
        .i_res        (res_bus),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length in cycles. Most gaps are short, a few are long enough to
    // let the block run dry or back up completely.
    function automatic int pick_gap(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0 || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random Q2.21 coefficient over the whole signed 24-bit range.
    function automatic int rand_coef();
        return $signed($urandom) >>> 8;
    endfunction

    // Next random sample: a mix of full-range noise, a slow walk that a
    // low-pass filter actually tracks, the two rails, and values near zero.
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) walk = 16'($urandom);
        else if (roll < 70) walk = 16'(walk + $urandom_range(0, 2000) - 1000);
        else if (roll < 85) walk = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else walk = 16'($urandom_range(0, 64) - 32);
        return walk;
    endfunction

    // The receiver drops ready for random stretches while its mode asks for
    // gaps, and keeps it high otherwise. Ready changes only at falling edges.
    initial begin : receiver
        int hold;
        hold = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (take_mode == 0) begin
                res_bus.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 60) begin
                res_bus.ready <= 1'b1;
                hold = $urandom_range(0, 5);
            end else begin
                res_bus.ready <= 1'b0;
                hold = pick_gap(1);
            end
        end
    end

    // The watchdog counts cycles in which nothing moves on any port. A block
    // that hangs or loses a result ends the run here.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
                i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL biquad_lowpass_filter_core");
        $finish;
    end

    // Offers one item after a random gap and returns at the rising edge at
    // which it is taken. When the gap is zero, valid simply stays high from
    // the previous item, so it is never lowered and raised in one step.
    task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap(send_mode);
        @(negedge i_clk);
        if (gap > 0) begin
            smp_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_bus.valid  <= 1'b1;
        smp_bus.kind   <= kind;
        smp_bus.sample <= smp;
        do @(posedge i_clk); while (!smp_bus.ready);
    endtask

    // Stops offering items and waits until every expected result has come
    // out, then lets the given number of extra cycles pass.
    task automatic drain(input int extra);
        @(negedge i_clk);
        smp_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // One register write; the enable stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Rewrites every register, but only once the block has gone idle.
    task automatic configure(input logic bypass, input int b0, input int b1, input int b2,
                             input int a1, input int a2, input logic [PRIME_W-1:0] prime);
        drain(SETTLE_CYCLES);
        write_reg(REG_BYPASS, {31'b0, bypass});
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        write_reg(REG_PRIME, prime);
        end_writes();
    endtask

    // Loads one of three Butterworth designs (cutoff at a tenth, a fiftieth
    // and a quarter of the sample rate), optionally nudging the feedforward
    // taps so that the DC gain is not exactly one.
    task automatic apply_design(input int sel, input logic jitter);
        int b0, b1, b2, a1, a2, nudge;
        logic [PRIME_W-1:0] prime;
        case (sel)
            0: begin
                b0 = 141463; b1 = 282926; b2 = 141463;
                a1 = -2397002; a2 = 865699; prime = 242892;
            end
            1: begin
                b0 = 7595; b1 = 15190; b2 = 7595;
                a1 = -3822478; a2 = 1755686; prime = 4523950;
            end
            default: begin
                b0 = 614242; b1 = 1228484; b2 = 614242;
                a1 = 0; a2 = 359810; prime = 55939;
            end
        endcase
        nudge = jitter ? $urandom_range(0, 128) - 64 : 0;
        configure(1'b0, b0 + nudge, b1 - nudge, b2 + nudge, a1, a2, prime);
    endtask

    initial begin : stimulus
        int ph;
        int n;
        int roll;

        // Every input starts at a known value while reset is held.
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_BYPASS;
        i_cfg_data     = '0;
        smp_bus.valid  = 1'b0;
        smp_bus.kind   = KIND_FILTER;
        smp_bus.sample = '0;
        walk           = '0;
        send_mode      = 1;
        take_mode      = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the block is in bypass: samples come back unchanged,
        // including the rails, and a prime with a zero scale loads zeros.
        send_item(KIND_FILTER, 16'sd0);
        send_item(KIND_FILTER, 16'sh7FFF);
        send_item(KIND_FILTER, 16'sh8000);
        send_item(KIND_FILTER, -16'sd1);
        send_item(KIND_PRIME, 16'sd12345);

        // Still in bypass, a write past the end of the register list must
        // change nothing. A prime item here loads the delays but does not
        // shift them, which shows in the first filtered items afterwards.
        configure(1'b1, 0, 0, 0, 0, 0, 242892);
        write_reg(REG_UNUSED, '1);
        end_writes();
        send_item(KIND_PRIME, 16'sd1000);

        // Leave bypass with a well-behaved design and let the primed
        // delays play out, then hit both rails and prime from each.
        apply_design(0, 1'b0);
        send_item(KIND_FILTER, 16'sd1000);
        send_item(KIND_FILTER, 16'sd1000);
        send_item(KIND_FILTER, 16'sd1000);
        send_item(KIND_FILTER, 16'sh8000);
        send_item(KIND_FILTER, 16'sh7FFF);
        send_item(KIND_PRIME, 16'sh8000);
        send_item(KIND_PRIME, 16'sh7FFF);
        send_item(KIND_FILTER, 16'sd0);

        // Largest feedforward taps, most negative feedback taps and the
        // largest prime scale: priming saturates the delays, the feedback
        // sum overflows so the sample stands in for it, and the output clips.
        configure(1'b0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, '1);
        send_item(KIND_PRIME, 16'sh7FFF);
        send_item(KIND_FILTER, 16'sh8000);
        send_item(KIND_FILTER, 16'sh7FFF);
        send_item(KIND_PRIME, 16'sh8000);
        send_item(KIND_FILTER, 16'sd0);

        // The opposite corner, with a zero prime scale.
        configure(1'b0, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, '0);
        send_item(KIND_FILTER, 16'sh7FFF);
        send_item(KIND_FILTER, 16'sh8000);
        send_item(KIND_FILTER, 16'sd1);
        send_item(KIND_PRIME, 16'sh7FFF);

        // Random phases. Most run a stable design so that the delay line
        // carries meaningful history; some use arbitrary registers, which
        // mostly saturate, and some run in bypass. Each phase picks its own
        // idling on both sides, and now and then the sender waits for all
        // results to come out before it goes on.
        for (ph = 0; ph < PHASES; ph++) begin
            roll = $urandom_range(0, 9);
            if (ph == 0 || roll < 6)
                apply_design($urandom_range(0, 2), $urandom_range(0, 1));
            else if (roll < 8)
                configure(1'b0, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), $urandom);
            else
                configure(1'b1, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), $urandom);
            send_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            take_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            walk = '0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0)
                    drain(0);
                send_item(($urandom_range(0, 9) == 0) ? KIND_PRIME : KIND_FILTER,
                          next_sample());
            end
        end

        // Wait for the last results and a while beyond, so that a stray
        // extra result would still be caught, then give the verdict.
        drain(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("PASS biquad_lowpass_filter_core");
        else
            $display("FAIL biquad_lowpass_filter_core");
        $finish;
    end

endmodule

[files.f]
design/bqlp_pkg.sv
design/bqlp_in_if.sv
design/bqlp_out_if.sv
design/biquad_lowpass_filter_core.sv
design/bqlp_chk.sv
test/bqlp_result_checker.sv
test/tb_top.sv
